// ===== design/oilpc_pkg.sv =====
package oilpc_pkg;

    // Cache geometry. NUM_SETS must be a power of two: the set is the low
    // address bits.
    localparam int NUM_SETS   = 64;
    localparam int NUM_WAYS   = 8;
    localparam int DATA_WIDTH = 32;

    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int TAG_W  = 48;

    // Stream payload layout.
    localparam int PC_LSB      = 0;
    localparam int ADDR_LSB    = PC_LSB + TAG_W;
    localparam int EDATA_LSB   = ADDR_LSB + TAG_W;
    localparam int EDATA_W     = 32;
    localparam int IN_TDATA_W  = EDATA_LSB + EDATA_W;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_LOOKUP = 1'b1
    } t_state;

    typedef struct packed {
        logic                  valid;
        logic [RANK_W-1:0]     rank;
        logic [TAG_W-1:0]      tag;
        logic [DATA_WIDTH-1:0] data;
    } t_way;

    typedef t_way [NUM_WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ===== design/oilpc_ram.sv =====
module oilpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/oilpc_ctrl.sv =====
module oilpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_tvalid,
    output logic              o_in_tready,
    input  oilpc_pkg::t_status i_status,
    output oilpc_pkg::t_cmd    o_cmd
);

    oilpc_pkg::t_state r_state;
    oilpc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oilpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_tready   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            oilpc_pkg::S_IDLE: begin
                // No transfer is taken while reset is held.
                o_in_tready   = i_rst_n;
                o_cmd.capture = i_in_tvalid && i_rst_n;
                if (i_in_tvalid && i_rst_n) begin
                    n_state = oilpc_pkg::S_LOOKUP;
                end
            end
            oilpc_pkg::S_LOOKUP: begin
                // Hold the row until the output register can take the result.
                o_cmd.commit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = oilpc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oilpc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/oilpc_dp.sv =====
module oilpc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  oilpc_pkg::t_cmd                     i_cmd,
    output oilpc_pkg::t_status                  o_status,
    input  logic                                i_in_tuser,
    input  logic [oilpc_pkg::IN_TDATA_W-1:0]    i_in_tdata,
    output logic                                o_out_tvalid,
    input  logic                                i_out_tready,
    output logic                                o_out_tuser,
    output logic [oilpc_pkg::OUT_TDATA_W-1:0]   o_out_tdata
);

    // Item registers.
    logic                              r_op;
    logic [oilpc_pkg::TAG_W-1:0]       r_tag;
    logic [oilpc_pkg::SET_W-1:0]       r_set;
    logic [oilpc_pkg::DATA_WIDTH-1:0]  r_data;

    logic [oilpc_pkg::NUM_SETS-1:0]    r_row_valid;
    logic                              r_out_valid;
    logic                              r_out_hit;
    logic [oilpc_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [oilpc_pkg::TAG_W-1:0]       in_addr;
    logic [oilpc_pkg::SET_W-1:0]       in_set;
    logic [oilpc_pkg::ROW_W-1:0]       rd_data;
    oilpc_pkg::t_row                   row;
    oilpc_pkg::t_row                   n_row;
    logic                              wr_en;

    logic [oilpc_pkg::NUM_WAYS-1:0]    match;
    logic [oilpc_pkg::NUM_WAYS-1:0]    free;
    logic [oilpc_pkg::NUM_WAYS-1:0]    oldest;
    logic [oilpc_pkg::WAY_W-1:0]       found_way;
    logic [oilpc_pkg::WAY_W-1:0]       free_way;
    logic [oilpc_pkg::WAY_W-1:0]       oldest_way;
    logic [oilpc_pkg::WAY_W-1:0]       tgt_way;
    logic                              hit;
    logic                              bump_all;
    logic [oilpc_pkg::RANK_W-1:0]      old_rank;
    logic [oilpc_pkg::OUT_TDATA_W-1:0] n_out_data;

    assign in_addr = i_in_tdata[oilpc_pkg::ADDR_LSB +: oilpc_pkg::TAG_W];
    assign in_set  = in_addr[oilpc_pkg::SET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_in_tuser;
            r_tag  <= i_in_tdata[oilpc_pkg::PC_LSB +: oilpc_pkg::TAG_W];
            r_set  <= in_set;
            r_data <= (oilpc_pkg::DATA_WIDTH)'(
                i_in_tdata[oilpc_pkg::EDATA_LSB +: oilpc_pkg::EDATA_W]);
        end
    end

    oilpc_ram #(
        .WIDTH (oilpc_pkg::ROW_W),
        .DEPTH (oilpc_pkg::NUM_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_set),
        .i_wdata (n_row),
        .i_re    (i_cmd.capture),
        .i_raddr (in_set),
        .o_rdata (rd_data)
    );

    // A set never written since reset reads as all ways invalid.
    assign row = r_row_valid[r_set] ? oilpc_pkg::t_row'(rd_data) : '0;

    always_comb begin
        for (int k = 0; k < oilpc_pkg::NUM_WAYS; k++) begin
            match[k]  = row[k].valid && (row[k].tag == r_tag);
            free[k]   = !row[k].valid;
            oldest[k] = row[k].valid &&
                        (row[k].rank == (oilpc_pkg::RANK_W)'(oilpc_pkg::NUM_WAYS - 1));
        end
    end

    // Lowest-numbered way wins each search.
    always_comb begin
        found_way  = '0;
        free_way   = '0;
        oldest_way = '0;
        for (int k = oilpc_pkg::NUM_WAYS - 1; k >= 0; k--) begin
            if (match[k]) begin
                found_way = (oilpc_pkg::WAY_W)'(k);
            end
            if (free[k]) begin
                free_way = (oilpc_pkg::WAY_W)'(k);
            end
            if (oldest[k]) begin
                oldest_way = (oilpc_pkg::WAY_W)'(k);
            end
        end
    end

    assign hit      = |match;
    assign bump_all = !hit && (|free);
    assign tgt_way  = hit ? found_way : ((|free) ? free_way : oldest_way);
    assign old_rank = row[tgt_way].rank;

    // Target way becomes most recent. On a fill every valid way ages by one;
    // otherwise only the ways more recent than the target age.
    always_comb begin
        n_row = row;
        for (int k = 0; k < oilpc_pkg::NUM_WAYS; k++) begin
            if ((oilpc_pkg::WAY_W)'(k) == tgt_way) begin
                n_row[k].rank = '0;
                if (r_op == oilpc_pkg::OP_INSERT) begin
                    n_row[k].valid = 1'b1;
                    n_row[k].tag   = r_tag;
                    n_row[k].data  = r_data;
                end
            end else if (row[k].valid && (bump_all || (row[k].rank < old_rank))) begin
                n_row[k].rank = row[k].rank + 1'b1;
            end
        end
    end

    // A lookup miss leaves the set untouched.
    assign wr_en = i_cmd.commit && (hit || (r_op == oilpc_pkg::OP_INSERT));

    assign n_out_data = (hit && (r_op == oilpc_pkg::OP_LOOKUP))
                        ? (oilpc_pkg::OUT_TDATA_W)'(row[found_way].data) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_valid[r_set] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit  <= hit;
            r_out_data <= n_out_data;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_tready;
    assign o_out_tvalid      = r_out_valid;
    assign o_out_tuser       = r_out_hit;
    assign o_out_tdata       = r_out_data;

endmodule

// ===== design/offset_indexed_lru_pattern_cache_core.sv =====
// Set-associative pattern cache with LRU replacement, indexed by the low
// bits of the access address and tagged by the full program counter.
// Each transfer on the slave channel is one access; each access gives
// exactly one transfer on the master channel, in order.
//   Slave channel: s_axis_tuser is the operation (lookup or insert);
//   s_axis_tdata carries pc_tag, access_address and entry_data.
//   Master channel: m_axis_tuser is the hit flag; m_axis_tdata is the
//   stored handle on a lookup hit and zero otherwise.
// The block takes a new access only after the current one is committed.
// The set row lives in a single-port-read memory: one step reads the row,
// the next compares the tags, updates the recency ranks, writes the row
// back and registers the result in the output register.
// Reset clears the controller, the output valid flag and one valid flag per
// set, so every set reads as empty right away; no transfer is taken while
// reset is held.
// When the master side stalls, the finished result waits in the output
// register and the block holds its current access; a new access is taken
// while an earlier result still waits to be transferred.
module offset_indexed_lru_pattern_cache_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tuser: operation (bit 0).
    input  logic                              s_axis_tuser,
    // tdata: pc_tag [47:0], access_address [95:48], entry_data [127:96].
    input  logic [oilpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tuser: hit (bit 0).
    output logic                              m_axis_tuser,
    // tdata: data_out [31:0].
    output logic [oilpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    oilpc_pkg::t_cmd    cmd;
    oilpc_pkg::t_status status;

    // Controller: one access in flight, waits for the output register.
    oilpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: row memory, tag compare, recency update, output register.
    oilpc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_in_tuser   (s_axis_tuser),
        .i_in_tdata   (s_axis_tdata),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_out_tuser  (m_axis_tuser),
        .o_out_tdata  (m_axis_tdata)
    );

endmodule

// ===== design/oilpc_checker.sv =====
module oilpc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              s_axis_tuser,
    input logic [oilpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic                              m_axis_tuser,
    input logic [oilpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Only one access is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an access is in flight");

    // A miss returns no data.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss returned nonzero data");

endmodule

bind offset_indexed_lru_pattern_cache_core oilpc_checker u_oilpc_checker (.*);
